>>> rtl/rcsr_pkg.sv
// ============================================================================
// rcsr_pkg
// Shared codes, types and address decode for the RV32 CSR access unit.
// ============================================================================
package rcsr_pkg;

    localparam int XLEN = 32;

    // Operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRIV    = 2'd1;
    localparam logic [1:0] ST_RO      = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // Read-only encoding of address bits 11:10
    localparam logic [1:0] ADDR_RO = 2'b11;

    // Supported CSR numbers
    localparam logic [11:0] CSR_SSCRATCH = 12'h140;
    localparam logic [11:0] CSR_SATP     = 12'h180;
    localparam logic [11:0] CSR_MSCRATCH = 12'h340;
    localparam logic [11:0] CSR_MCYCLE   = 12'hB00;
    localparam logic [11:0] CSR_MINSTRET = 12'hB02;
    localparam logic [11:0] CSR_MCYCLEH  = 12'hB80;
    localparam logic [11:0] CSR_MINSTRTH = 12'hB82;
    localparam logic [11:0] CSR_CYCLE    = 12'hC00;
    localparam logic [11:0] CSR_INSTRET  = 12'hC02;
    localparam logic [11:0] CSR_CYCLEH   = 12'hC80;
    localparam logic [11:0] CSR_INSTRTH  = 12'hC82;

    // satp field widths
    localparam int PPN_W  = 22;
    localparam int ASID_W = 9;

    typedef enum logic [2:0] {
        K_NONE,
        K_SSCRATCH,
        K_SATP,
        K_MSCRATCH,
        K_CNT_LO,
        K_CNT_HI
    } csr_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the accepted transaction
        logic commit;  // execute and load the result register
    } ctrl_cmd_t;

    function automatic csr_kind_t csr_decode(input logic [11:0] addr);
        csr_kind_t k;
        unique case (addr)
            CSR_SSCRATCH: k = K_SSCRATCH;
            CSR_SATP:     k = K_SATP;
            CSR_MSCRATCH: k = K_MSCRATCH;
            CSR_MCYCLE, CSR_MINSTRET, CSR_CYCLE, CSR_INSTRET:
                k = K_CNT_LO;
            CSR_MCYCLEH, CSR_MINSTRTH, CSR_CYCLEH, CSR_INSTRTH:
                k = K_CNT_HI;
            default:      k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/rcsr_if.sv
// ============================================================================
// rcsr_if
// Valid/ready channels for CSR access requests and responses.
// ============================================================================
interface rcsr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [11:0] csr_address;
    logic [31:0] write_value;
    logic [1:0]  current_privilege;

    modport source (output valid, operation, csr_address, write_value,
                    current_privilege, input ready);
    modport sink   (input valid, operation, csr_address, write_value,
                    current_privilege, output ready);
endinterface

interface rcsr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [1:0]  status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

>>> rtl/rcsr_ctrl.sv
// ============================================================================
// rcsr_ctrl
// Sequencer: accepts one transaction, executes it once the result register
// is free, and tracks the result register's valid flag.
// ============================================================================
module rcsr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rcsr_pkg::ctrl_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Issue commands
    always_comb
    begin
        req_ready  = (state_reg == S_IDLE);
        cmd.load   = req_valid && (state_reg == S_IDLE);
        cmd.commit = (state_reg == S_EXEC) && (!out_valid_reg || rsp_ready);
    end

    // Next state and result flag
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

>>> rtl/rcsr_dp.sv
// ============================================================================
// rcsr_dp
// Datapath: transaction capture, access checks, CSR storage with
// read-modify-write, and the result register.
// ============================================================================
module rcsr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  rcsr_pkg::ctrl_cmd_t cmd,
    input  logic [1:0]          operation,
    input  logic [11:0]         csr_address,
    input  logic [31:0]         write_value,
    input  logic [1:0]          current_privilege,
    output logic [31:0]         read_value,
    output logic [1:0]          status
);

    // Captured transaction
    logic [1:0]  op_reg;
    logic [11:0] addr_reg;
    logic [31:0] wval_reg;
    logic [1:0]  priv_reg;

    // CSR storage
    logic [31:0]                 sscratch_reg;
    logic [31:0]                 mscratch_reg;
    logic [63:0]                 counter_reg;
    logic [rcsr_pkg::PPN_W-1:0]  ppn_reg;
    logic [rcsr_pkg::ASID_W-1:0] asid_reg;
    logic                        mode_reg;

    // Result register
    logic [31:0] rdata_reg;
    logic [1:0]  status_reg;

    rcsr_pkg::csr_kind_t kind;
    logic [1:0]          st;
    logic [31:0]         old_val;
    logic [31:0]         new_val;
    logic                wr_en;

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            addr_reg <= csr_address;
            wval_reg <= write_value;
            priv_reg <= current_privilege;
        end
    end

    // Check access and read old value
    always_comb
    begin
        kind = rcsr_pkg::csr_decode(addr_reg);
        if (priv_reg < addr_reg[9:8])
            st = rcsr_pkg::ST_PRIV;
        else if (op_reg != rcsr_pkg::OP_READ && addr_reg[11:10] == rcsr_pkg::ADDR_RO)
            st = rcsr_pkg::ST_RO;
        else if (kind == rcsr_pkg::K_NONE)
            st = rcsr_pkg::ST_INVALID;
        else
            st = rcsr_pkg::ST_OK;

        case (kind)
            rcsr_pkg::K_SSCRATCH: old_val = sscratch_reg;
            rcsr_pkg::K_MSCRATCH: old_val = mscratch_reg;
            rcsr_pkg::K_SATP:     old_val = {mode_reg, asid_reg, ppn_reg};
            rcsr_pkg::K_CNT_LO:   old_val = counter_reg[31:0];
            rcsr_pkg::K_CNT_HI:   old_val = counter_reg[63:32];
            default:              old_val = '0;
        endcase
        if (st != rcsr_pkg::ST_OK)
            old_val = '0;
    end

    // Form the modified value
    always_comb
    begin
        case (op_reg)
            rcsr_pkg::OP_WRITE: new_val = wval_reg;
            rcsr_pkg::OP_SET:   new_val = old_val | wval_reg;
            rcsr_pkg::OP_CLEAR: new_val = old_val & ~wval_reg;
            default:            new_val = old_val;
        endcase
        wr_en = cmd.commit && (st == rcsr_pkg::ST_OK) && (op_reg != rcsr_pkg::OP_READ);
    end

    // Write back CSR storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sscratch_reg <= '0;
            mscratch_reg <= '0;
            counter_reg  <= '0;
            ppn_reg      <= '0;
            asid_reg     <= '0;
            mode_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (kind)
                rcsr_pkg::K_SSCRATCH: sscratch_reg <= new_val;
                rcsr_pkg::K_MSCRATCH: mscratch_reg <= new_val;
                rcsr_pkg::K_SATP:
                begin
                    mode_reg <= new_val[31];
                    asid_reg <= new_val[30:22];
                    ppn_reg  <= new_val[21:0];
                end
                rcsr_pkg::K_CNT_LO:   counter_reg[31:0]  <= new_val;
                rcsr_pkg::K_CNT_HI:   counter_reg[63:32] <= new_val;
                default:              ;
            endcase
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rdata_reg  <= old_val;
            status_reg <= st;
        end
    end

    assign read_value = rdata_reg;
    assign status     = status_reg;

endmodule

>>> rtl/riscv_csr_access_unit.sv
// Sequence: an accepted transaction is captured in S_IDLE and executed in S_EXEC
// once the result register is free; its response then stays valid until taken.
// A new request is taken only once the last one has executed, and is taken even
// while a response still waits.
// Reset: asynchronous, clears all CSRs (scratch, satp, counter) to zero.
// ============================================================================
// riscv_csr_access_unit
// RV32 CSR access unit: privilege and read-only checks, read-modify-write of
// sscratch, satp, mscratch and the shared 64-bit cycle/instret counter.
// ============================================================================
module riscv_csr_access_unit (
    input  logic       clk,
    input  logic       rst_n,
    rcsr_req_if.sink   req,
    rcsr_rsp_if.source rsp
);

    rcsr_pkg::ctrl_cmd_t cmd;

    rcsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    rcsr_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .operation         (req.operation),
        .csr_address       (req.csr_address),
        .write_value       (req.write_value),
        .current_privilege (req.current_privilege),
        .read_value        (rsp.read_value),
        .status            (rsp.status)
    );

    // Accepting a transaction leaves the unit busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while a transaction is in progress");

    // Execution always presents a response
    a_commit_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("executed transaction produced no response");

    // Capture and execute never coincide
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.commit}))
        else $error("capture and execute in the same cycle");

    // Failed accesses return zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != rcsr_pkg::ST_OK) |-> (rsp.read_value == '0))
        else $error("failed access returned nonzero data");

endmodule
